// ===== sv/lsb_pixel_text_embed_extract_assert.svh =====
// Assertion macros used by the checker of the pixel text embed and extract block.
`ifndef LSB_PIXEL_TEXT_EMBED_EXTRACT_ASSERT_SVH
`define LSB_PIXEL_TEXT_EMBED_EXTRACT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge of clk.
`define LPTE_ASSERT_HOLDS(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge of clk.
`define LPTE_ASSERT_NEXT(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lpte_pkg.sv =====
// Types and constants shared by the pixel text embed and extract block.
`default_nettype none

package lpte_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned BUF_W      = 16;
  localparam int unsigned PEND_W     = 5;
  localparam int unsigned ABITS_W    = 3;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CHAN_W-1:0]  CH_BANG      = 8'h21;
  localparam logic [CHAN_W-1:0]  CH_CARET     = 8'h5E;
  localparam logic [PEND_W-1:0]  PUSH_MAX     = 5'd8;
  localparam logic [PEND_W-1:0]  BITS_PER_PIX = 5'd3;
  localparam logic [PEND_W-1:0]  BITS_PER_MSG = 5'd8;
  localparam logic [ABITS_W-1:0] ABITS_LAST   = 3'd7;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef struct packed {
    logic [BUF_W-1:0]   bit_buffer;
    logic [PEND_W-1:0]  bits_pending;
    logic               terminator_pushed;
    logic               last_byte_was_bang;
    logic [CHAN_W-1:0]  assembled_byte;
    logic [ABITS_W-1:0] assembled_bits;
    logic               done_flag;
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [CHAN_W-1:0] msg_byte;
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic              final_pixel;
  } item_t;

  // Packed from the top down, so out_red lands in the lowest bits.
  typedef struct packed {
    logic              truncated;
    logic              finished;
    logic              underrun;
    logic              accepted;
    logic [CHAN_W-1:0] byte_out;
    logic              byte_valid;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
  } result_t;

  localparam int unsigned OUT_RES_W = $bits(result_t);
  localparam int unsigned OUT_PAD_W = OUT_DATA_W - OUT_RES_W;

endpackage

`default_nettype wire

// ===== sv/lsb_pixel_text_embed_extract.sv =====
// Top level of the LSB pixel text embed and extract block.
// An input beat is held in the input register and its result in the result register.
// One beat per cycle unless the output stalls; combinational step logic updates the state.
// The output register accepts a new result in the cycle its current one is taken.
// Reset (rst_n low, synchronous) clears all message state, the mode and both valid flags.
`default_nettype none

module lsb_pixel_text_embed_extract (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // msg_byte, pixel_red, pixel_green, pixel_blue
  input  wire logic [lpte_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation
  input  wire logic [0:0]                         in_tuser,
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_red, out_green, out_blue, byte_valid, byte_out, accepted, underrun,
  // finished, truncated, zero padding
  output logic [lpte_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [0:0]                         cfg_data
);

  logic              s1_valid_r;
  lpte_pkg::item_t   s1_item_r;
  lpte_pkg::item_t   in_item;
  lpte_pkg::state_t  state_r;
  lpte_pkg::state_t  state_nxt;
  lpte_pkg::result_t res_nxt;
  lpte_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              mode_r;
  logic              advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_item.operation   = lpte_pkg::op_t'(in_tuser[0]);
    in_item.msg_byte    = in_tdata[7:0];
    in_item.pixel_red   = in_tdata[15:8];
    in_item.pixel_green = in_tdata[23:16];
    in_item.pixel_blue  = in_tdata[31:24];
    in_item.final_pixel = in_tlast;
  end

  lpte_step u_step (
    .mode_decode (mode_r),
    .st          (state_r),
    .it          (s1_item_r),
    .st_nxt      (state_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      mode_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data[0];
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{lpte_pkg::OUT_PAD_W{1'b0}}, out_res_r};

endmodule

`default_nettype wire

// ===== sv/lpte_step.sv =====
// Next-state and result logic for one item of the pixel text embed and extract block.
`default_nettype none

module lpte_step (
  input  wire logic            mode_decode,
  input  wire lpte_pkg::state_t st,
  input  wire lpte_pkg::item_t  it,
  output lpte_pkg::state_t      st_nxt,
  output lpte_pkg::result_t     res
);

  logic [lpte_pkg::CHAN_W-1:0]  ch [3];
  logic [lpte_pkg::BUF_W-1:0]   shifted;
  logic [lpte_pkg::PEND_W-1:0]  pend_left;
  logic [lpte_pkg::CHAN_W-1:0]  abyte;
  logic [lpte_pkg::ABITS_W-1:0] abits;
  logic                         dec_done;
  logic                         bang;

  always_comb begin
    st_nxt    = st;
    res       = '0;
    ch[0]     = it.pixel_red;
    ch[1]     = it.pixel_green;
    ch[2]     = it.pixel_blue;
    shifted   = {{(lpte_pkg::BUF_W - lpte_pkg::CHAN_W){1'b0}}, it.msg_byte} << st.bits_pending[3:0];
    pend_left = '0;
    abyte     = st.assembled_byte;
    abits     = st.assembled_bits;
    dec_done  = 1'b0;
    bang      = st.last_byte_was_bang;

    if (it.operation == lpte_pkg::OP_PUSH) begin
      ch[0] = '0;
      ch[1] = '0;
      ch[2] = '0;
      if (!mode_decode && !st.done_flag && !st.terminator_pushed &&
          st.bits_pending <= lpte_pkg::PUSH_MAX) begin
        st_nxt.bit_buffer   = st.bit_buffer | shifted;
        st_nxt.bits_pending = st.bits_pending + lpte_pkg::BITS_PER_MSG;
        if (st.last_byte_was_bang && it.msg_byte == lpte_pkg::CH_CARET) begin
          st_nxt.terminator_pushed = 1'b1;
        end
        st_nxt.last_byte_was_bang = (it.msg_byte == lpte_pkg::CH_BANG);
        res.accepted = 1'b1;
      end
    end else if (!st.done_flag) begin
      if (!mode_decode) begin
        if (st.terminator_pushed && st.bits_pending == '0) begin
          st_nxt.done_flag = 1'b1;
        end else if (st.bits_pending >= lpte_pkg::BITS_PER_PIX || st.terminator_pushed) begin
          ch[0][0] = st.bit_buffer[0];
          ch[1][0] = st.bit_buffer[1];
          ch[2][0] = st.bit_buffer[2];
          st_nxt.bit_buffer = st.bit_buffer >> 3;
          if (st.bits_pending >= lpte_pkg::BITS_PER_PIX) begin
            pend_left = st.bits_pending - lpte_pkg::BITS_PER_PIX;
          end
          st_nxt.bits_pending = pend_left;
          if (st.terminator_pushed && pend_left == '0) begin
            st_nxt.done_flag = 1'b1;
          end
        end else begin
          res.underrun = 1'b1;
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (!dec_done) begin
            abyte = abyte | ({{(lpte_pkg::CHAN_W - 1){1'b0}}, ch[k][0]} << abits);
            if (abits == lpte_pkg::ABITS_LAST) begin
              abits          = '0;
              res.byte_valid = 1'b1;
              res.byte_out   = abyte;
              if (bang && abyte == lpte_pkg::CH_CARET) begin
                dec_done = 1'b1;
              end
              bang  = (abyte == lpte_pkg::CH_BANG);
              abyte = '0;
            end else begin
              abits = abits + 3'd1;
            end
          end
        end
        st_nxt.assembled_byte     = abyte;
        st_nxt.assembled_bits     = abits;
        st_nxt.last_byte_was_bang = bang;
        st_nxt.done_flag          = dec_done;
      end
    end

    res.out_red   = ch[0];
    res.out_green = ch[1];
    res.out_blue  = ch[2];
    res.finished  = st_nxt.done_flag;
    res.truncated = (it.operation == lpte_pkg::OP_PIXEL) && it.final_pixel &&
                    !st_nxt.done_flag;
  end

endmodule

`default_nettype wire

// ===== sv/lpte_checker.sv =====
// Port-level checker for the LSB pixel text embed and extract block, with its bind.
`default_nettype none
`include "lsb_pixel_text_embed_extract_assert.svh"

module lpte_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [lpte_pkg::OUT_DATA_W-1:0] out_tdata
);

  lpte_pkg::result_t res_w;
  logic              seen_fin_r;

  assign res_w = out_tdata[lpte_pkg::OUT_RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_fin_r <= 1'b0;
    end else if (out_tvalid && out_tready && res_w.finished) begin
      seen_fin_r <= 1'b1;
    end
  end

  `LPTE_ASSERT_NEXT(a_reset_empty, 1'b0, !rst_n,
                    !out_tvalid && in_tready, "Reset left a beat pending")
  `LPTE_ASSERT_NEXT(a_out_hold, !rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "Stalled output beat changed")
  `LPTE_ASSERT_HOLDS(a_ready_when_empty, !rst_n, !out_tvalid,
                     in_tready, "Input stalled with an empty output")
  `LPTE_ASSERT_HOLDS(a_finished_sticky, !rst_n, out_tvalid && seen_fin_r,
                     res_w.finished, "Finished dropped before reset")

endmodule

bind lsb_pixel_text_embed_extract lpte_checker u_lpte_checker (.*);

`default_nettype wire

// ===== bench/lpte_result_check.sv =====
`timescale 1ns / 100ps
// Result checker for the LSB pixel text embed and extract block: predicts every output beat.
module lpte_result_check (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [lpte_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [0:0]                     in_tuser,
  input  wire logic                           in_tlast,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [lpte_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [0:0]                     cfg_data,
  output int unsigned                         fail_count,
  output int unsigned                         outstanding,
  output int unsigned                         checked_count,
  output int unsigned                         decoded_count,
  output int unsigned                         underrun_count
);
  import lpte_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  logic               decode_mode;
  logic [BUF_W-1:0]   msg_bits;
  logic [PEND_W-1:0]  msg_bit_count;
  logic               term_pushed;
  logic               prev_was_bang;
  logic [CHAN_W-1:0]  gather_byte;
  logic [ABITS_W-1:0] gather_count;
  logic               message_done;

  result_t expected_pixels[$];

  function automatic result_t advance_stego(input item_t beat);
    result_t           r;
    logic [CHAN_W-1:0] chan [3];
    r = '0;
    chan[0] = beat.pixel_red;
    chan[1] = beat.pixel_green;
    chan[2] = beat.pixel_blue;
    if (beat.operation == OP_PUSH) begin
      if (!decode_mode && !message_done && !term_pushed && msg_bit_count <= PUSH_MAX) begin
        msg_bits = msg_bits | (BUF_W'(beat.msg_byte) << msg_bit_count);
        msg_bit_count = msg_bit_count + BITS_PER_MSG;
        if (prev_was_bang && beat.msg_byte == CH_CARET) term_pushed = 1'b1;
        prev_was_bang = (beat.msg_byte == CH_BANG);
        r.accepted = 1'b1;
      end
    end else if (!message_done) begin
      if (!decode_mode) begin
        if (term_pushed && msg_bit_count == '0) begin
          message_done = 1'b1;
        end else if (msg_bit_count >= BITS_PER_PIX || term_pushed) begin
          // Bits above the pending count are always zero, so a short tail pads with zeros.
          for (int k = 0; k < 3; k++) chan[k][0] = msg_bits[k];
          msg_bits = msg_bits >> BITS_PER_PIX;
          msg_bit_count = (msg_bit_count >= BITS_PER_PIX) ? msg_bit_count - BITS_PER_PIX : '0;
          if (term_pushed && msg_bit_count == '0) message_done = 1'b1;
        end else begin
          r.underrun = 1'b1;
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (!message_done) begin
            gather_byte[gather_count] = chan[k][0];
            if (gather_count == ABITS_LAST) begin
              gather_count = '0;
              r.byte_valid = 1'b1;
              r.byte_out = gather_byte;
              if (prev_was_bang && gather_byte == CH_CARET) message_done = 1'b1;
              prev_was_bang = (gather_byte == CH_BANG);
              gather_byte = '0;
            end else begin
              gather_count = gather_count + 1'b1;
            end
          end
        end
      end
    end
    if (beat.operation == OP_PIXEL) begin
      r.out_red = chan[0];
      r.out_green = chan[1];
      r.out_blue = chan[2];
      r.truncated = beat.final_pixel && !message_done;
    end
    r.finished = message_done;
    return r;
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf("rgb %h %h %h byte %b:%h acc %b und %b done %b trunc %b",
                     r.out_red, r.out_green, r.out_blue, r.byte_valid, r.byte_out,
                     r.accepted, r.underrun, r.finished, r.truncated);
  endfunction

  task automatic flag_error(input string detail);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, detail);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    item_t   beat;
    if (!rst_n) begin
      decode_mode = 1'b0;
      msg_bits = '0;
      msg_bit_count = '0;
      term_pushed = 1'b0;
      prev_was_bang = 1'b0;
      gather_byte = '0;
      gather_count = '0;
      message_done = 1'b0;
      expected_pixels.delete();
      fail_count = 0;
      checked_count = 0;
      decoded_count = 0;
      underrun_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_RES_W-1:0];
        checked_count++;
        if (expected_pixels.size() == 0) begin
          flag_error({"result beat with nothing expected: ", show_result(got)});
        end else begin
          want = expected_pixels.pop_front();
          if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
              got.out_blue !== want.out_blue || got.byte_valid !== want.byte_valid ||
              got.byte_out !== want.byte_out || got.accepted !== want.accepted ||
              got.underrun !== want.underrun || got.finished !== want.finished ||
              got.truncated !== want.truncated) begin
            flag_error({"expected ", show_result(want), " got ", show_result(got)});
          end
        end
      end
      if (in_tvalid && in_tready) begin
        beat.operation = op_t'(in_tuser[0]);
        beat.msg_byte = in_tdata[7:0];
        beat.pixel_red = in_tdata[15:8];
        beat.pixel_green = in_tdata[23:16];
        beat.pixel_blue = in_tdata[31:24];
        beat.final_pixel = in_tlast;
        want = advance_stego(beat);
        expected_pixels.push_back(want);
        if (want.underrun) underrun_count++;
        if (want.byte_valid) decoded_count++;
      end
      if (cfg_valid && cfg_ready) decode_mode = cfg_data[0];
    end
    outstanding <= expected_pixels.size();
  end

endmodule

// ===== bench/tb_lsb_pixel_text_embed_extract.sv =====
`timescale 1ns / 100ps
// Testbench top: drives message pushes, pixels and mode writes into the block and gives the verdict.
module tb_lsb_pixel_text_embed_extract;
  import lpte_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned BLOCK_ITEMS   = 150;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES    = 10;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned push_count = 0;
  int unsigned pixel_count = 0;
  int unsigned mode_writes = 0;
  int unsigned tail_pixels;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned checked_count;
  int unsigned decoded_count;
  int unsigned underrun_count;
  bit          finish_by_decode;
  logic        lsb_stream[$];

  lsb_pixel_text_embed_extract dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  lpte_result_check result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count),
    .decoded_count  (decoded_count),
    .underrun_count (underrun_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
             outstanding);
    $display("FAIL");
    $finish;
  end

  function automatic item_t make_push(input logic [7:0] value);
    item_t it;
    it.operation = OP_PUSH;
    it.msg_byte = value;
    it.pixel_red = 8'($urandom);
    it.pixel_green = 8'($urandom);
    it.pixel_blue = 8'($urandom);
    it.final_pixel = 1'($urandom);
    return it;
  endfunction

  function automatic item_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic fin);
    item_t it;
    it.operation = OP_PIXEL;
    it.msg_byte = 8'($urandom);
    it.pixel_red = r;
    it.pixel_green = g;
    it.pixel_blue = b;
    it.final_pixel = fin;
    return it;
  endfunction

  // Text bytes never carry a caret, so the terminator only appears where it is planned.
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] value;
    if ($urandom_range(9) == 0) return CH_BANG;
    do value = 8'($urandom_range(255)); while (value == CH_CARET);
    return value;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.pixel_blue, it.pixel_green, it.pixel_red, it.msg_byte};
    in_tuser <= it.operation;
    in_tlast <= it.final_pixel;
    if (it.operation == OP_PUSH) push_count++;
    else pixel_count++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic queue_hidden_byte(input logic [7:0] value);
    for (int k = 0; k < 8; k++) lsb_stream.push_back(value[k]);
  endtask

  // Decode pixels carry a planned bit stream in their LSBs, aligned from reset.
  task automatic send_hidden_pixel(input logic [6:0] hi_r, input logic [6:0] hi_g,
                                   input logic [6:0] hi_b, input logic fin);
    logic [2:0] lsbs;
    while (lsb_stream.size() < 3) queue_hidden_byte(pick_text_byte());
    for (int k = 0; k < 3; k++) lsbs[k] = lsb_stream.pop_front();
    send_item(make_pixel({hi_r, lsbs[0]}, {hi_g, lsbs[1]}, {hi_b, lsbs[2]}, fin));
  endtask

  task automatic send_random_pixel();
    send_item(make_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(31) == 0));
  endtask

  task automatic send_random_hidden();
    send_hidden_pixel(7'($urandom), 7'($urandom), 7'($urandom), $urandom_range(31) == 0);
  endtask

  task automatic wait_drained(input int unsigned settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_mode(input logic decode);
    wait_drained(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_data <= decode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  task automatic set_pressure(input int unsigned phase);
    case (phase)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_idle_pct = 48;
        recv_stall_pct <= 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct <= 48;
      end
      default: begin
        send_idle_pct = 26;
        recv_stall_pct <= 26;
      end
    endcase
  endtask

  // Pushes and pixels are mixed so the bit buffer swings between empty and full.
  task automatic run_embed_block(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 30) send_item(make_push(pick_text_byte()));
      else send_random_pixel();
    end
  endtask

  task automatic run_extract_block(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) send_item(make_push(8'($urandom)));
      else send_random_hidden();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(make_pixel(8'hFF, 8'h00, 8'hAA, 1'b0));
    send_item(make_pixel(8'h00, 8'hFF, 8'h55, 1'b1));
    send_item(make_push(8'h00));
    send_item(make_push(8'hFF));
    send_item(make_push(CH_BANG));
    send_item(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_item(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
    send_item(make_push(CH_CARET));
    send_item(make_pixel(8'hA5, 8'h5A, 8'hC3, 1'b0));
    send_item(make_push(CH_CARET));
    repeat (3) send_random_pixel();
    send_item(make_push(CH_BANG));
    send_random_pixel();

    write_mode(1'b1);
    send_item(make_push(CH_CARET));
    send_hidden_pixel(7'h7F, 7'h7F, 7'h7F, 1'b0);
    send_hidden_pixel(7'h00, 7'h00, 7'h00, 1'b0);
    send_hidden_pixel(7'($urandom), 7'($urandom), 7'($urandom), 1'b1);
    repeat (4) send_random_hidden();

    for (int unsigned p = 0; p < 4; p++) begin
      set_pressure(p);
      for (int unsigned b = 0; b < 3; b++) begin
        write_mode(((p + b) % 2) == 1);
        if (((p + b) % 2) == 1) run_extract_block(BLOCK_ITEMS);
        else run_embed_block(BLOCK_ITEMS);
      end
    end

    // Drain the bit buffer, then push the terminator and one byte that must be refused.
    write_mode(1'b0);
    repeat (6) send_random_pixel();
    send_item(make_push(CH_BANG));
    send_item(make_push(CH_CARET));
    send_item(make_push(8'h41));
    finish_by_decode = 1'($urandom_range(1));
    if (finish_by_decode) begin
      write_mode(1'b1);
      queue_hidden_byte(CH_BANG);
      queue_hidden_byte(CH_CARET);
      tail_pixels = (lsb_stream.size() + 2) / 3;
      repeat (tail_pixels) send_random_hidden();
      repeat (6) send_random_hidden();
    end else begin
      repeat (12) send_random_pixel();
    end

    write_mode(1'b0);
    repeat (3) begin
      send_item(make_push(8'($urandom)));
      send_item(make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1));
    end
    write_mode(1'b1);
    repeat (3) begin
      send_item(make_push(8'($urandom)));
      send_random_hidden();
    end

    wait_drained(END_CYCLES);
    $display("Sent %0d pushes and %0d pixels with %0d mode writes over four pressure phases.",
             push_count, pixel_count, mode_writes);
    $display("Checked %0d results: %0d bytes decoded, %0d underruns, ended by %s.",
             checked_count, decoded_count, underrun_count,
             finish_by_decode ? "decoding the terminator" : "embedding the terminator tail");
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
